// File: design/secd_pkg.sv
// secd_pkg: constants, types and code-position mapping for the 50-bit header secded checker
// used by secd_syndrome, secd_correct and the secded_header_checker_50bit_core top level
// no dependencies
`default_nettype none

package secd_pkg;

    localparam int unsigned HDR_W       = 50;
    localparam int unsigned DATA_W      = 43;
    localparam int unsigned SYN_W       = 6;
    localparam int unsigned OVERALL_BIT = 6;
    localparam int unsigned DATA_BASE   = 7;
    localparam int unsigned CODE_LAST   = 49;
    localparam int unsigned IN_TDATA_W  = ((HDR_W + 7) / 8) * 8;
    localparam int unsigned OUT_USED_W  = HDR_W + 2 + SYN_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef logic [HDR_W-1:0] hdr_t;
    typedef logic [SYN_W-1:0] syn_t;

    typedef struct packed {
        syn_t syndrome;
        logic ov_wrong;
    } chk_t;

    typedef struct packed {
        syn_t syndrome;
        logic uncorrectable;
        logic error;
        hdr_t header;
    } result_t;

    // interleaved code position of a header bit, zero for the overall parity bit
    function automatic syn_t pos_of_hdr(input int unsigned hb);
        int unsigned p;
        int unsigned pc;
        int unsigned dc;
        syn_t        r;
        r  = '0;
        pc = 0;
        dc = 0;
        for (p = 1; p <= CODE_LAST; p++)
        begin
            if ((p & (p - 1)) == 0)
            begin
                if (pc == hb)
                    r = SYN_W'(p);
                pc++;
            end
            else
            begin
                if (DATA_BASE + dc == hb)
                    r = SYN_W'(p);
                dc++;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/secd_syndrome.sv
// secd_syndrome: recomputes hamming syndrome and overall parity of one header
// depends on secd_pkg
`default_nettype none

module secd_syndrome (
    input  wire secd_pkg::hdr_t header,
    output secd_pkg::chk_t      chk
);

    secd_pkg::syn_t syn;
    logic           ov;

    always_comb
    begin
        syn = '0;
        ov  = 1'b0;
        for (int unsigned i = 0; i < secd_pkg::HDR_W; i++)
        begin
            if (i != secd_pkg::OVERALL_BIT)
            begin
                syn = syn ^ (secd_pkg::pos_of_hdr(i) & {secd_pkg::SYN_W{header[i]}});
                ov  = ov ^ header[i];
            end
        end
    end

    assign chk.syndrome = syn;
    assign chk.ov_wrong = ov ^ header[secd_pkg::OVERALL_BIT];

endmodule

`default_nettype wire

// File: design/secd_correct.sv
// secd_correct: flags and single-bit correction from the syndrome check
// depends on secd_pkg
`default_nettype none

module secd_correct (
    input  wire secd_pkg::hdr_t  header,
    input  wire secd_pkg::chk_t  chk,
    input  wire                  correct_enable,
    output secd_pkg::result_t    result
);

    logic           syn_err;
    secd_pkg::hdr_t flip;

    assign syn_err = (chk.syndrome != '0);

    always_comb
    begin
        flip = '0;
        for (int unsigned i = 0; i < secd_pkg::HDR_W; i++)
        begin
            if (i == secd_pkg::OVERALL_BIT)
                flip[i] = correct_enable & ~syn_err & chk.ov_wrong;
            else
                flip[i] = correct_enable & syn_err & (chk.syndrome == secd_pkg::pos_of_hdr(i));
        end
    end

    assign result.header        = header ^ flip;
    assign result.error         = syn_err | chk.ov_wrong;
    assign result.uncorrectable = syn_err & ~chk.ov_wrong;
    assign result.syndrome      = chk.syndrome;

endmodule

`default_nettype wire

// File: design/secded_header_checker_50bit_core.sv
// secded_header_checker_50bit_core: extended hamming check and correction of 50-bit headers
// depends on secd_pkg, secd_syndrome, secd_correct
//
// usage
//   s_axis carries one raw header per item in tdata[49:0]
//   m_axis returns one result per item: corrected or passed header, error,
//   uncorrectable and the six-bit syndrome
//   cfg_wr_en / cfg_wr_data write correct_enable, change it only while idle
// path: an accepted item lands in the input register, then moves to the result register
//   and shows on m_axis from there
// throughput: one item per cycle while m_axis_tready is high, limited only by
//   the two register stages moving together; the xor trees fit between them
// reset: rst_n clears both stage valid bits and correct_enable
// stall: while m_axis_tready is low the result register holds its item and
//   the input register can still take one more item; after that
//   s_axis_tready drops until the result is taken
`default_nettype none

module secded_header_checker_50bit_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_wr_en,
    input  wire                                  cfg_wr_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // raw header
    input  wire [secd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // checked header, error, uncorrectable, syndrome
    output logic [secd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic              correct_enable_reg;
    logic              in_valid_reg;
    secd_pkg::hdr_t    hdr_reg;
    logic              out_valid_reg;
    secd_pkg::result_t res_reg;
    secd_pkg::chk_t    chk;
    secd_pkg::result_t res_next;
    logic              out_load;
    logic              in_load;

    assign out_load      = ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = ~in_valid_reg | out_load;
    assign in_load       = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            correct_enable_reg <= 1'b0;
        else if (cfg_wr_en)
            correct_enable_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            hdr_reg <= s_axis_tdata[secd_pkg::HDR_W-1:0];
        if (out_load && in_valid_reg)
            res_reg <= res_next;
    end

    secd_syndrome u_syndrome (
        .header (hdr_reg),
        .chk    (chk)
    );

    secd_correct u_correct (
        .header         (hdr_reg),
        .chk            (chk),
        .correct_enable (correct_enable_reg),
        .result         (res_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(secd_pkg::OUT_TDATA_W - secd_pkg::OUT_USED_W){1'b0}}, res_reg};

endmodule

`default_nettype wire

// File: design/secd_checker.sv
// secd_checker: port-level assertions for secded_header_checker_50bit_core, with its bind
// depends on secd_pkg
`default_nettype none

module secd_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [secd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int unsigned ERR_BIT = secd_pkg::HDR_W;
    localparam int unsigned UNC_BIT = secd_pkg::HDR_W + 1;
    localparam int unsigned SYN_LO  = secd_pkg::HDR_W + 2;

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_unc_is_err : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[UNC_BIT] |-> m_axis_tdata[ERR_BIT])
        else $error("uncorrectable without error");

    a_syn_is_err : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[SYN_LO +: secd_pkg::SYN_W] != '0)
        |-> m_axis_tdata[ERR_BIT])
        else $error("nonzero syndrome without error");

    a_pad_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[secd_pkg::OUT_TDATA_W-1:secd_pkg::OUT_USED_W] == '0))
        else $error("result padding not zero");

endmodule

bind secded_header_checker_50bit_core secd_checker u_secd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/secded_header_checker_50bit_core_test.sv
// secded_header_checker_50bit_core_test: stream-level test of the 50-bit header secded checker
// predicts every result from the accepted header and the correct_enable setting, checks in order
// depends on secd_pkg and secded_header_checker_50bit_core
`default_nettype none

module secded_header_checker_50bit_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_LIMIT = 200000;

    class header_board;
        secd_pkg::result_t expected_q[$];
        bit                correct_on;
        int unsigned       mismatches;

        static function int unsigned bit_at_pos(input int unsigned p);
            if ((p & (p - 1)) == 0)
                return $clog2(p);
            return secd_pkg::DATA_BASE + p - 1 - $clog2(p);
        endfunction

        static function secd_pkg::syn_t syndrome_of(input secd_pkg::hdr_t h);
            secd_pkg::syn_t s;
            int unsigned    p;
            s = '0;
            for (p = 1; p <= secd_pkg::CODE_LAST; p++)
            begin
                if (h[bit_at_pos(p)])
                    s ^= secd_pkg::syn_t'(p);
            end
            return s;
        endfunction

        static function logic parity_of(input secd_pkg::hdr_t h);
            return ^{h[secd_pkg::HDR_W-1:secd_pkg::DATA_BASE], h[secd_pkg::OVERALL_BIT-1:0]};
        endfunction

        function void note_header(input secd_pkg::hdr_t h);
            secd_pkg::result_t r;
            secd_pkg::syn_t    s;
            logic              wrong;
            s     = syndrome_of(h);
            wrong = parity_of(h) != h[secd_pkg::OVERALL_BIT];
            r.header = h;
            if (correct_on)
            begin
                if (s != 0 && s <= secd_pkg::CODE_LAST)
                    r.header[bit_at_pos(s)] = ~r.header[bit_at_pos(s)];
                if (s == 0 && wrong)
                    r.header[secd_pkg::OVERALL_BIT] = ~r.header[secd_pkg::OVERALL_BIT];
            end
            r.error         = (s != 0) || wrong;
            r.uncorrectable = (s != 0) && !wrong;
            r.syndrome      = s;
            expected_q.push_back(r);
        endfunction

        function void check_result(input secd_pkg::result_t got);
            secd_pkg::result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item %h", $time, got);
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.header !== exp_r.header)
            begin
                $display("%0t: header expected %h actual %h", $time, exp_r.header, got.header);
                mismatches++;
            end
            if (got.error !== exp_r.error)
            begin
                $display("%0t: error expected %b actual %b", $time, exp_r.error, got.error);
                mismatches++;
            end
            if (got.uncorrectable !== exp_r.uncorrectable)
            begin
                $display("%0t: uncorrectable expected %b actual %b", $time,
                         exp_r.uncorrectable, got.uncorrectable);
                mismatches++;
            end
            if (got.syndrome !== exp_r.syndrome)
            begin
                $display("%0t: syndrome expected %h actual %h", $time,
                         exp_r.syndrome, got.syndrome);
                mismatches++;
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic                             cfg_wr_data = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [secd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [secd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    header_board    board = new();
    int unsigned    send_idle = 0;
    int unsigned    recv_idle = 0;
    int unsigned    cycles = 0;
    secd_pkg::hdr_t directed_q[$];

    secded_header_checker_50bit_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(secd_pkg::result_t'(m_axis_tdata[secd_pkg::OUT_USED_W-1:0]));
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    function automatic secd_pkg::hdr_t make_codeword(input logic [secd_pkg::DATA_W-1:0] d);
        secd_pkg::hdr_t h;
        h = '0;
        h[secd_pkg::HDR_W-1:secd_pkg::DATA_BASE] = d;
        h[secd_pkg::SYN_W-1:0] = header_board::syndrome_of(h);
        h[secd_pkg::OVERALL_BIT] = header_board::parity_of(h);
        return h;
    endfunction

    function automatic logic [secd_pkg::DATA_W-1:0] random_data();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[secd_pkg::DATA_W-1:0];
    endfunction

    function automatic secd_pkg::hdr_t random_header();
        secd_pkg::hdr_t h;
        int unsigned    roll;
        int unsigned    a;
        int unsigned    b;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return secd_pkg::hdr_t'({$urandom, $urandom});
        h = make_codeword(random_data());
        a = $urandom_range(0, secd_pkg::HDR_W - 1);
        b = (a + $urandom_range(1, secd_pkg::HDR_W - 1)) % secd_pkg::HDR_W;
        if (roll >= 40)
            h[a] = ~h[a];
        if (roll >= 80)
            h[b] = ~h[b];
        if (roll >= 95)
            h[secd_pkg::SYN_W-1:0] ^= secd_pkg::syn_t'($urandom_range(50, 63));
        return h;
    endfunction

    task automatic send_header(input secd_pkg::hdr_t h);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(secd_pkg::IN_TDATA_W - secd_pkg::HDR_W){1'b0}}, h};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_header(h);
    endtask

    task automatic set_correction(input bit on);
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        board.correct_on = on;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        foreach (directed_q[i])
            send_header(directed_q[i]);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic run_random(input int unsigned n, input int unsigned s_idle,
                              input int unsigned r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (n) send_header(random_header());
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        secd_pkg::hdr_t base;
        base = make_codeword(43'h2A5_5AA5_C33C);
        directed_q.push_back('0);
        directed_q.push_back('1);
        directed_q.push_back(make_codeword('1));
        directed_q.push_back(base ^ (secd_pkg::hdr_t'(1) << 0));
        directed_q.push_back(base ^ (secd_pkg::hdr_t'(1) << 3));
        directed_q.push_back(base ^ (secd_pkg::hdr_t'(1) << 7));
        directed_q.push_back(base ^ (secd_pkg::hdr_t'(1) << (secd_pkg::HDR_W - 1)));
        directed_q.push_back(base ^ (secd_pkg::hdr_t'(1) << secd_pkg::OVERALL_BIT));
        directed_q.push_back(base ^ (secd_pkg::hdr_t'(1) << 10) ^ (secd_pkg::hdr_t'(1) << 30));
        directed_q.push_back(base ^ (secd_pkg::hdr_t'(1) << secd_pkg::OVERALL_BIT)
                             ^ (secd_pkg::hdr_t'(1) << 20));
        // syndrome 63, past the code, overall parity matching
        directed_q.push_back(base ^ secd_pkg::hdr_t'(6'h3F));
        // syndrome 50, past the code, overall parity wrong
        directed_q.push_back(base ^ secd_pkg::hdr_t'(6'h32));

        send_idle = 33;
        recv_idle = 47;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_correction(1'b0);
        run_directed();
        set_correction(1'b1);
        run_directed();

        set_correction(1'b1);
        run_random(100, 33, 47);
        set_correction(1'b0);
        run_random(100, 33, 47);
        set_correction(1'b1);
        run_random(100, 47, 33);
        set_correction(1'b0);
        run_random(100, 47, 33);
        set_correction(1'b1);
        run_random(100, 0, 0);
        set_correction(1'b0);
        run_random(100, 0, 0);

        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
